// ----- sv/apnn_pkg.sv -----
`timescale 1ns / 1ps

package apnn_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;

    localparam int IN_W    = 16;
    localparam int NBR_W   = 6;
    localparam int DIST_W  = 25;
    localparam int FRAC_W  = 8;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int D2_W    = 2 * COORD_BITS + 1;
    localparam int RAD_W   = 2 * DIST_W;
    localparam int D2_KEEP = RAD_W - 2 * FRAC_W;
    localparam int SQRT_CNT_W = $clog2(DIST_W + 1);

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] rd_addr;
        logic             cap_i;
        logic             scan_vld;
        logic             scan_skip;
        logic             sqrt_start;
        logic             out_load;
        logic             res_last;
        logic             res_dropped;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic sqrt_busy;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [NBR_W-1:0]  neighbor_index;
        logic [DIST_W-1:0] distance;
        logic              has_neighbor;
        logic              points_dropped;
        logic              last_result;
    } t_res;

endpackage

// ----- sv/apnn_pt_if.sv -----
`timescale 1ns / 1ps

interface apnn_pt_if import apnn_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] x_coord;
    logic signed [IN_W-1:0] y_coord;
    logic                   last_point;

    modport source (output valid, x_coord, y_coord, last_point, input ready);
    modport sink   (input valid, x_coord, y_coord, last_point, output ready);
endinterface

// ----- sv/apnn_res_if.sv -----
`timescale 1ns / 1ps

interface apnn_res_if import apnn_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NBR_W-1:0]  neighbor_index;
    logic [DIST_W-1:0] distance;
    logic              has_neighbor;
    logic              points_dropped;
    logic              last_result;

    modport source (output valid, neighbor_index, distance, has_neighbor,
                    points_dropped, last_result, input ready);
    modport sink   (input valid, neighbor_index, distance, has_neighbor,
                    points_dropped, last_result, output ready);
endinterface

// ----- sv/apnn_sqrt.sv -----
`timescale 1ns / 1ps

module apnn_sqrt import apnn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_busy,
    output logic [DIST_W-1:0] o_root
);

    localparam int REM_W = DIST_W + 2;

    logic [RAD_W-1:0]      r_rad;
    logic [REM_W-1:0]      r_rem;
    logic [DIST_W-1:0]     r_root;
    logic [SQRT_CNT_W-1:0] r_cnt;
    logic                  r_busy;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // one root bit per cycle, two radicand bits brought down
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= SQRT_CNT_W'(DIST_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - SQRT_CNT_W'(1);
            r_busy <= (r_cnt != SQRT_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[DIST_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ----- sv/apnn_dp.sv -----
`timescale 1ns / 1ps

module apnn_dp import apnn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [COORD_BITS-1:0] i_wr_x,
    input  logic [COORD_BITS-1:0] i_wr_y,
    input  logic                  i_out_ready,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    output t_res                  o_res
);

    logic [COORD_BITS-1:0] r_mem_x [MAX_POINTS];
    logic [COORD_BITS-1:0] r_mem_y [MAX_POINTS];
    logic [COORD_BITS-1:0] r_rd_x, r_rd_y;
    logic [COORD_BITS-1:0] r_xi, r_yi;

    logic                  r_s0_vld, r_s1_vld, r_s2_vld;
    logic                  r_s0_skip, r_s1_skip, r_s2_skip;
    logic [IDX_W-1:0]      r_s0_j, r_s1_j, r_s2_j;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [SQ_W-1:0]       r_sqx, r_sqy;

    logic                  r_found;
    logic [IDX_W-1:0]      r_best_j;
    logic [D2_W-1:0]       r_best;

    logic                  r_out_vld;
    t_res                  r_res;

    logic [COORD_BITS:0]   ddx, ddy;
    logic [COORD_BITS:0]   adx, ady;
    logic [D2_W-1:0]       sum;
    logic                  better;
    logic [63:0]           best64;
    logic                  sat;
    logic [RAD_W-1:0]      rad;
    logic [DIST_W-1:0]     root;
    logic                  sqrt_busy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem_x[i_cmd.wr_addr] <= i_wr_x;
            r_mem_y[i_cmd.wr_addr] <= i_wr_y;
        end
        r_rd_x <= r_mem_x[i_cmd.rd_addr];
        r_rd_y <= r_mem_y[i_cmd.rd_addr];
    end

    always_comb begin
        ddx = {r_xi[COORD_BITS-1], r_xi} - {r_rd_x[COORD_BITS-1], r_rd_x};
        ddy = {r_yi[COORD_BITS-1], r_yi} - {r_rd_y[COORD_BITS-1], r_rd_y};
        adx = ddx[COORD_BITS] ? (~ddx + 1'b1) : ddx;
        ady = ddy[COORD_BITS] ? (~ddy + 1'b1) : ddy;
        sum = D2_W'(r_sqx) + D2_W'(r_sqy);
        // strict less keeps the earliest index on a tie
        better = r_s2_vld && !r_s2_skip && (!r_found || (sum < r_best));
        best64 = 64'(r_best);
        sat    = |best64[63:D2_KEEP];
        rad    = {best64[D2_KEEP-1:0], (2 * FRAC_W)'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_s0_vld <= i_cmd.scan_vld;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
            if (i_cmd.cap_i) begin
                r_found <= 1'b0;
            end else if (better) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_i) begin
            r_xi <= r_rd_x;
            r_yi <= r_rd_y;
        end
        r_s0_j    <= i_cmd.rd_addr;
        r_s0_skip <= i_cmd.scan_skip;
        r_s1_j    <= r_s0_j;
        r_s1_skip <= r_s0_skip;
        r_dx      <= adx[COORD_BITS-1:0];
        r_dy      <= ady[COORD_BITS-1:0];
        r_s2_j    <= r_s1_j;
        r_s2_skip <= r_s1_skip;
        r_sqx     <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sqy     <= SQ_W'(r_dy) * SQ_W'(r_dy);
        if (better) begin
            r_best   <= sum;
            r_best_j <= r_s2_j;
        end
    end

    apnn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_rad   (rad),
        .o_busy  (sqrt_busy),
        .o_root  (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res.neighbor_index <= r_found ? NBR_W'(r_best_j) : '0;
            r_res.distance       <= !r_found ? '0 : (sat ? '1 : root);
            r_res.has_neighbor   <= r_found;
            r_res.points_dropped <= i_cmd.res_dropped;
            r_res.last_result    <= i_cmd.res_last;
        end
    end

    assign o_sts.pipe_busy = r_s0_vld | r_s1_vld | r_s2_vld;
    assign o_sts.sqrt_busy = sqrt_busy;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;
    assign o_out_valid     = r_out_vld;
    assign o_res           = r_res;

endmodule

// ----- sv/apnn_ctrl.sv -----
`timescale 1ns / 1ps

module apnn_ctrl import apnn_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_RDI,
        S_CAPI,
        S_SCAN,
        S_DRAIN,
        S_SQST,
        S_SQWT,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;

    logic             room;
    logic             j_last;
    logic             i_last;

    always_comb begin
        room   = (r_cnt < CNT_W'(MAX_POINTS));
        j_last = (CNT_W'(r_j) == (r_cnt - CNT_W'(1)));
        i_last = (CNT_W'(r_i) == (r_cnt - CNT_W'(1)));

        o_in_ready        = (r_state == S_LOAD);
        o_cmd             = '0;
        o_cmd.wr_addr     = r_cnt[IDX_W-1:0];
        o_cmd.rd_addr     = (r_state == S_SCAN) ? r_j : r_i;
        o_cmd.res_last    = i_last;
        o_cmd.res_dropped = r_ovf;
        unique case (r_state)
            S_LOAD:  o_cmd.wr_en = i_in_valid && room;
            S_CAPI:  o_cmd.cap_i = 1'b1;
            S_SCAN: begin
                o_cmd.scan_vld  = 1'b1;
                o_cmd.scan_skip = (r_j == r_i);
            end
            S_SQST:  o_cmd.sqrt_start = 1'b1;
            S_OUT:   o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_in_valid) begin
                        if (room) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_last) begin
                            r_i     <= '0;
                            r_state <= S_RDI;
                        end
                    end
                end
                S_RDI:  r_state <= S_CAPI;
                S_CAPI: begin
                    r_j     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (j_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (!i_sts.pipe_busy) begin
                        r_state <= S_SQST;
                    end
                end
                S_SQST: r_state <= S_SQWT;
                S_SQWT: begin
                    if (!i_sts.sqrt_busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        if (i_last) begin
                            // set answered: clear for the next one
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_state <= S_RDI;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a pending transaction");

    a_sqrt_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sqrt_start |-> !i_sts.pipe_busy && !i_sts.sqrt_busy)
        else $error("root started before search finished");

    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load && o_cmd.res_last |=> r_cnt == '0 && !r_ovf)
        else $error("point store not cleared after last result");

endmodule

// ----- sv/all_points_nearest_neighbor_2d.sv -----
`timescale 1ns / 1ps

// All-points nearest neighbor search over a set of 2D points.
// i_pt takes one point per transaction; last_point closes the set and
// starts the search. Up to MAX_POINTS points are stored; later points of
// the set, the closing one included, are dropped and flagged on every
// result. o_res returns one transaction per stored point, in load order,
// with the nearest other point's index and the distance (8 fraction bits).
// Per result the block reads the point, scans all n stored points through
// a three-stage distance pipeline, then runs a bit-serial square root.
// Results are worked out one at a time on the single memory read port
// and the one root unit. Loading accepts one point per cycle.
// i_pt.ready is high only while points are being loaded. A stalled o_res
// holds the search at the next result; the last result of a set waits in
// the output register while loading of the next set goes on.
// Synchronous reset empties the point store and clears the dropped flag
// and any pending result; no clearing pass is needed.
module all_points_nearest_neighbor_2d import apnn_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    apnn_pt_if.sink      i_pt,
    apnn_res_if.source   o_res
);

    t_dp_cmd               cmd;
    t_dp_sts               sts;
    t_res                  res;
    logic                  out_valid;
    logic [COORD_BITS-1:0] wr_x, wr_y;
    logic [31:0]           x_ext, y_ext;

    assign x_ext = 32'($unsigned(i_pt.x_coord));
    assign y_ext = 32'($unsigned(i_pt.y_coord));
    assign wr_x  = x_ext[COORD_BITS-1:0];
    assign wr_y  = y_ext[COORD_BITS-1:0];

    apnn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .i_in_last  (i_pt.last_point),
        .i_sts      (sts),
        .o_in_ready (i_pt.ready),
        .o_cmd      (cmd)
    );

    apnn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_wr_x      (wr_x),
        .i_wr_y      (wr_y),
        .i_out_ready (o_res.ready),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .o_res       (res)
    );

    assign o_res.valid          = out_valid;
    assign o_res.neighbor_index = res.neighbor_index;
    assign o_res.distance       = res.distance;
    assign o_res.has_neighbor   = res.has_neighbor;
    assign o_res.points_dropped = res.points_dropped;
    assign o_res.last_result    = res.last_result;

endmodule
